/* hdl/assert_macros.svh */
// Assertion macros used by the parser RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while rst is high.
`define DCTP_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dctp assertion failed");

// Next-cycle implication, sampled on clk and disabled while rst is high.
`define DCTP_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dctp assertion failed");

`endif

/* hdl/dctp_pkg.sv */
// Types, character codes and name tables for the drawing command text parser.
package dctp_pkg;

  localparam int CHAR_BITS      = 8;
  localparam int COORD_OUT_BITS = 12;
  localparam int NUMBER_BITS    = 16;
  localparam int NUM_SLOTS      = 4;
  localparam int SLOT_BITS      = 2;
  localparam int NAME_CHARS     = 6;
  localparam int KIND_COUNT     = 4;
  localparam int COLOUR_COUNT   = 6;
  localparam int COLOUR_BITS    = 3;
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 12;

  typedef logic [CHAR_BITS-1:0] char_t;
  typedef char_t [0:NAME_CHARS-1] name_t;

  // Character codes with a meaning of their own.
  localparam char_t CH_NEWLINE = 8'd10;
  localparam char_t CH_SPACE   = 8'd32;
  localparam char_t CH_COLON   = 8'd58;
  localparam char_t CH_COMMA   = 8'd44;
  localparam char_t CH_SEMI    = 8'd59;
  localparam char_t CH_ZERO    = 8'd48;
  localparam char_t CH_NINE    = 8'd57;

  // Configuration register indexes and their reset values.
  localparam logic [CFG_INDEX_BITS-1:0] REG_FULL_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FULL_HEIGHT = 2'd1;
  localparam logic [CFG_DATA_BITS-1:0]  FULL_WIDTH_RST  = 12'd640;
  localparam logic [CFG_DATA_BITS-1:0]  FULL_HEIGHT_RST = 12'd480;

  typedef enum logic [1:0] {
    KIND_BCKG   = 2'd0,
    KIND_LINE_H = 2'd1,
    KIND_LINE_V = 2'd2,
    KIND_RECT   = 2'd3
  } kind_t;

  typedef enum logic [COLOUR_BITS-1:0] {
    CLR_RED    = 3'd0,
    CLR_GREEN  = 3'd1,
    CLR_BLUE   = 3'd2,
    CLR_YELLOW = 3'd3,
    CLR_WHITE  = 3'd4,
    CLR_BLACK  = 3'd5
  } paint_t;

  typedef enum logic [1:0] {
    PH_KEYWORD = 2'd0,
    PH_NUMBERS = 2'd1,
    PH_COLOUR  = 2'd2
  } phase_t;

  // Name tables; short names are padded with spaces that the length excludes.
  localparam name_t KW_NAME [KIND_COUNT] = '{"BCKG  ", "LINE_H", "LINE_V", "RECT  "};
  localparam int    KW_LEN  [KIND_COUNT] = '{4, 6, 6, 4};
  localparam name_t CLR_NAME [COLOUR_COUNT] =
    '{"RED   ", "GREEN ", "BLUE  ", "YELLOW", "WHITE ", "BLACK "};
  localparam int    CLR_LEN  [COLOUR_COUNT] = '{3, 5, 4, 6, 5, 5};

  // Result of matching the word buffer against the keyword and colour names.
  typedef struct packed {
    logic    kw_hit;
    kind_t   kw_kind;
    logic    clr_hit;
    paint_t  clr_code;
  } match_t;

  // One command record as it leaves the parser.
  typedef struct packed {
    kind_t                     kind;
    paint_t                    colour;
    logic [COORD_OUT_BITS-1:0] x_start;
    logic [COORD_OUT_BITS-1:0] x_end;
    logic [COORD_OUT_BITS-1:0] y_start;
    logic [COORD_OUT_BITS-1:0] y_end;
    logic [NUMBER_BITS-1:0]    number;
  } record_t;

endpackage

/* hdl/dctp_word_match.sv */
// Compares the word buffer with the keyword names and the colour names.
module dctp_word_match #(
  parameter int WORD_CHARS = 8,
  parameter int FILL_BITS  = $clog2(WORD_CHARS + 1)
) (
  input  dctp_pkg::char_t        word_chars [WORD_CHARS],
  input  logic [FILL_BITS-1:0]   word_fill,
  output dctp_pkg::match_t       match
);
  import dctp_pkg::*;

  // A name matches when the fill equals its length and every stored char agrees.
  always_comb begin
    logic hit;
    hit   = 1'b0;
    match = '0;
    for (int k = 0; k < KIND_COUNT; k++) begin
      hit = (word_fill == FILL_BITS'(KW_LEN[k]));
      for (int j = 0; j < NAME_CHARS; j++) begin
        if (j < KW_LEN[k] && word_chars[j] != KW_NAME[k][j]) begin
          hit = 1'b0;
        end
      end
      if (hit) begin
        match.kw_hit  = 1'b1;
        match.kw_kind = kind_t'(2'(k));
      end
    end
    for (int k = 0; k < COLOUR_COUNT; k++) begin
      hit = (word_fill == FILL_BITS'(CLR_LEN[k]));
      for (int j = 0; j < NAME_CHARS; j++) begin
        if (j < CLR_LEN[k] && word_chars[j] != CLR_NAME[k][j]) begin
          hit = 1'b0;
        end
      end
      if (hit) begin
        match.clr_hit  = 1'b1;
        match.clr_code = paint_t'(COLOUR_BITS'(k));
      end
    end
  end

endmodule

/* hdl/dctp_parser.sv */
// Line parser: holds the per-line state and handles one character per step.
`include "assert_macros.svh"

module dctp_parser #(
  parameter int MAX_LINE_CHARS = 128,
  parameter int COORD_BITS     = 12,
  parameter int WORD_CHARS     = 8
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  step_en,
  input  dctp_pkg::char_t                       ch,
  input  logic [dctp_pkg::CFG_DATA_BITS-1:0]    full_width,
  input  logic [dctp_pkg::CFG_DATA_BITS-1:0]    full_height,
  output logic                                  rec_valid,
  output dctp_pkg::record_t                     rec
);
  import dctp_pkg::*;

  localparam int FILL_BITS = $clog2(WORD_CHARS + 1);
  localparam int IDX_BITS  = $clog2(WORD_CHARS);
  localparam int LEN_BITS  = $clog2(MAX_LINE_CHARS + 1);
  localparam int PROD_BITS = COORD_BITS + 4;
  localparam int WIDE_BITS = (COORD_BITS > COORD_OUT_BITS) ? COORD_BITS : COORD_OUT_BITS;

  // Line state.
  phase_t                 phase;
  phase_t                 phase_next;
  char_t                  word_chars [WORD_CHARS];
  logic [FILL_BITS-1:0]   word_fill;
  logic [LEN_BITS-1:0]    line_len;
  logic [COORD_BITS-1:0]  num [NUM_SLOTS];
  logic [SLOT_BITS-1:0]   slot;
  logic                   bad;
  kind_t                  kind;
  logic [NUMBER_BITS-1:0] count;

  // Character decode.
  logic                   is_nl;
  logic                   take;
  logic                   overlong;
  logic                   live;
  logic                   is_digit;
  logic                   kw_colon;
  logic                   num_digit;
  logic                   num_comma;
  logic                   num_semi;
  logic                   num_other;
  logic                   word_put;
  logic                   word_full;
  logic                   at_last;
  logic                   set_bad;
  logic                   emit;
  match_t                 match;

  // Number accumulation and output coordinates.
  logic [PROD_BITS-1:0]   prod_ext;
  logic [PROD_BITS-1:0]   prod;
  logic [COORD_BITS-1:0]  digit_next;
  logic [WIDE_BITS-1:0]   wide_v  [NUM_SLOTS];
  logic [COORD_OUT_BITS-1:0] coord_v [NUM_SLOTS];

  dctp_word_match #(
    .WORD_CHARS (WORD_CHARS),
    .FILL_BITS  (FILL_BITS)
  ) u_match (
    .word_chars (word_chars),
    .word_fill  (word_fill),
    .match      (match)
  );

  // Classify the incoming character against the current phase.
  always_comb begin
    is_nl     = (ch == CH_NEWLINE);
    take      = !is_nl && (ch != CH_SPACE) && !bad;
    overlong  = take && (line_len == LEN_BITS'(MAX_LINE_CHARS));
    live      = take && !overlong;
    is_digit  = (ch >= CH_ZERO) && (ch <= CH_NINE);
    kw_colon  = live && (phase == PH_KEYWORD) && (ch == CH_COLON);
    num_digit = live && (phase == PH_NUMBERS) && is_digit;
    num_comma = live && (phase == PH_NUMBERS) && (ch == CH_COMMA);
    num_semi  = live && (phase == PH_NUMBERS) && (ch == CH_SEMI);
    num_other = live && (phase == PH_NUMBERS) && !is_digit &&
                (ch != CH_COMMA) && (ch != CH_SEMI);
    word_put  = live && (((phase == PH_KEYWORD) && (ch != CH_COLON)) ||
                         (phase == PH_COLOUR));
    word_full = (word_fill == FILL_BITS'(WORD_CHARS));
    at_last   = (kind == KIND_RECT) ? (slot == SLOT_BITS'(3)) : (slot == SLOT_BITS'(2));
    set_bad   = overlong || (kw_colon && !match.kw_hit) || (num_comma && at_last) ||
                (num_semi && !at_last) || num_other || (word_put && word_full);
    emit      = is_nl && !bad && (phase == PH_COLOUR) && match.clr_hit;
  end

  // Multiply-by-ten accumulate with saturation at the coordinate maximum.
  always_comb begin
    prod_ext   = PROD_BITS'(num[slot]);
    prod       = (prod_ext << 3) + (prod_ext << 1) + PROD_BITS'(4'(ch - CH_ZERO));
    digit_next = (prod > PROD_BITS'({COORD_BITS{1'b1}})) ? {COORD_BITS{1'b1}}
                                                         : prod[COORD_BITS-1:0];
  end

  // Next parse phase.
  always_comb begin
    phase_next = phase;
    if (step_en) begin
      if (is_nl) begin
        phase_next = PH_KEYWORD;
      end else if (kw_colon && match.kw_hit) begin
        phase_next = (match.kw_kind == KIND_BCKG) ? PH_COLOUR : PH_NUMBERS;
      end else if (num_semi && at_last) begin
        phase_next = PH_COLOUR;
      end
    end
  end

  // Control state of the line and the running command number.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_KEYWORD;
      word_fill <= '0;
      line_len  <= '0;
      slot      <= '0;
      bad       <= 1'b0;
      kind      <= KIND_BCKG;
      count     <= '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        num[i] <= '0;
      end
    end else begin
      phase <= phase_next;
      if (step_en) begin
        if (is_nl) begin
          word_fill <= '0;
          line_len  <= '0;
          slot      <= '0;
          bad       <= 1'b0;
          kind      <= KIND_BCKG;
          for (int i = 0; i < NUM_SLOTS; i++) begin
            num[i] <= '0;
          end
          if (emit) begin
            count <= count + NUMBER_BITS'(1);
          end
        end else begin
          if (set_bad) begin
            bad <= 1'b1;
          end
          if (live) begin
            line_len <= line_len + LEN_BITS'(1);
          end
          if (kw_colon && match.kw_hit) begin
            kind      <= match.kw_kind;
            word_fill <= '0;
          end
          if (word_put && !word_full) begin
            word_fill <= word_fill + FILL_BITS'(1);
          end
          if (num_digit) begin
            num[slot] <= digit_next;
          end
          if (num_comma && !at_last) begin
            slot <= slot + SLOT_BITS'(1);
          end
        end
      end
    end
  end

  // Word buffer; only entries below the fill are ever compared.
  always_ff @(posedge clk) begin
    if (step_en && !is_nl && word_put && !word_full) begin
      word_chars[word_fill[IDX_BITS-1:0]] <= ch;
    end
  end

  // Coordinates are cut or padded to the output width.
  always_comb begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      wide_v[i]  = WIDE_BITS'(num[i]);
      coord_v[i] = wide_v[i][COORD_OUT_BITS-1:0];
    end
  end

  // Record assembly for the line that the newline closes.
  always_comb begin
    rec_valid   = step_en && emit;
    rec.kind    = kind;
    rec.colour  = match.clr_code;
    rec.number  = count;
    case (kind)
      KIND_BCKG: begin
        rec.x_start = '0;
        rec.x_end   = full_width;
        rec.y_start = '0;
        rec.y_end   = full_height;
      end
      KIND_LINE_H: begin
        rec.x_start = coord_v[0];
        rec.x_end   = coord_v[1];
        rec.y_start = coord_v[2];
        rec.y_end   = coord_v[2];
      end
      KIND_LINE_V: begin
        rec.x_start = coord_v[0];
        rec.x_end   = coord_v[0];
        rec.y_start = coord_v[1];
        rec.y_end   = coord_v[2];
      end
      default: begin
        rec.x_start = coord_v[0];
        rec.x_end   = coord_v[1];
        rec.y_start = coord_v[2];
        rec.y_end   = coord_v[3];
      end
    endcase
  end

  // A newline always returns the line to a clean keyword phase.
  `DCTP_ASSERT_NXT(a_nl_clears, step_en && is_nl, phase == PH_KEYWORD && line_len == '0 && !bad && word_fill == '0)
  // The command number advances by one exactly on an emitted record.
  `DCTP_ASSERT_NXT(a_count_step, rec_valid, count == NUMBER_BITS'($past(count) + NUMBER_BITS'(1)))
  `DCTP_ASSERT_NXT(a_count_hold, !rec_valid, $stable(count))
  // Only line keywords ever reach the number phase.
  `DCTP_ASSERT_IMP(a_numbers_kind, phase == PH_NUMBERS, kind != KIND_BCKG)

endmodule

/* hdl/draw_command_text_parser.sv */
// Top level: input register, configuration registers, parser and result register.
// A result is registered when the newline that closes its line leaves the input register.
// Throughput: one character per cycle as long as each result is taken when it appears.
// A result left waiting holds the character behind it, so input stalls until it is taken.
// Reset (rst, synchronous) empties both registers, clears the line state and the command
// number, and sets full_width to 640 and full_height to 480.
module draw_command_text_parser #(
  parameter int MAX_LINE_CHARS = 128,
  parameter int COORD_BITS     = 12,
  parameter int WORD_CHARS     = 8
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [dctp_pkg::CHAR_BITS-1:0]        char_code,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [1:0]                            command_kind,
  output logic [dctp_pkg::COLOUR_BITS-1:0]      colour_code,
  output logic [dctp_pkg::COORD_OUT_BITS-1:0]   x_start,
  output logic [dctp_pkg::COORD_OUT_BITS-1:0]   x_end,
  output logic [dctp_pkg::COORD_OUT_BITS-1:0]   y_start,
  output logic [dctp_pkg::COORD_OUT_BITS-1:0]   y_end,
  output logic [dctp_pkg::NUMBER_BITS-1:0]      command_number,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [dctp_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [dctp_pkg::CFG_DATA_BITS-1:0]    cfg_data
);
  import dctp_pkg::*;

  logic                     in_full;
  char_t                    in_char;
  logic                     fire;
  logic                     rec_valid;
  record_t                  rec;
  record_t                  out_rec;
  logic [CFG_DATA_BITS-1:0] full_width;
  logic [CFG_DATA_BITS-1:0] full_height;

  // The held character moves on when the result register can take a record.
  assign fire      = in_full && (!out_valid || out_ready);
  assign in_ready  = !in_full || fire;
  assign cfg_ready = 1'b1;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_full <= 1'b1;
    end else if (fire) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_char <= char_code;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      full_width  <= FULL_WIDTH_RST;
      full_height <= FULL_HEIGHT_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_FULL_WIDTH:  full_width  <= cfg_data;
        REG_FULL_HEIGHT: full_height <= cfg_data;
        default: ;
      endcase
    end
  end

  dctp_parser #(
    .MAX_LINE_CHARS (MAX_LINE_CHARS),
    .COORD_BITS     (COORD_BITS),
    .WORD_CHARS     (WORD_CHARS)
  ) u_parser (
    .clk         (clk),
    .rst         (rst),
    .step_en     (fire),
    .ch          (in_char),
    .full_width  (full_width),
    .full_height (full_height),
    .rec_valid   (rec_valid),
    .rec         (rec)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire && rec_valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && rec_valid) begin
      out_rec <= rec;
    end
  end

  assign command_kind   = out_rec.kind;
  assign colour_code    = out_rec.colour;
  assign x_start        = out_rec.x_start;
  assign x_end          = out_rec.x_end;
  assign y_start        = out_rec.y_start;
  assign y_end          = out_rec.y_end;
  assign command_number = out_rec.number;

endmodule

/* sim/tb_draw_command_text_parser.sv */
// Self-checking testbench for the drawing command text parser.
`timescale 1ns / 100ps

module tb_draw_command_text_parser;
  import dctp_pkg::*;

  localparam int LINE_LIMIT  = 128;
  localparam int WORD_LIMIT  = 8;
  localparam int COORD_LIMIT = 4095;
  localparam int STALL_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 8;
  localparam int PHASE_CHARS = 110;
  // Register indexes that address nothing.
  localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_HI = 2'd3;
  // In the directed text this character stands for a NUL byte.
  localparam char_t NUL_MARK = "@";

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  char_t char_code = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] command_kind;
  logic [COLOUR_BITS-1:0] colour_code;
  logic [COORD_OUT_BITS-1:0] x_start, x_end, y_start, y_end;
  logic [NUMBER_BITS-1:0] command_number;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;

  draw_command_text_parser dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .char_code(char_code),
    .out_valid(out_valid), .out_ready(out_ready),
    .command_kind(command_kind), .colour_code(colour_code),
    .x_start(x_start), .x_end(x_end), .y_start(y_start), .y_end(y_end),
    .command_number(command_number),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  // Keyword and colour spellings, and the number count each keyword takes.
  string kw_words[KIND_COUNT] = '{"BCKG", "LINE_H", "LINE_V", "RECT"};
  string colour_words[COLOUR_COUNT] = '{"RED", "GREEN", "BLUE", "YELLOW", "WHITE", "BLACK"};
  int kw_arg_count[KIND_COUNT] = '{0, 3, 3, 4};

  // Shadow copy of the parser's line state and registers.
  phase_t phase_now;
  char_t kw_buf[WORD_LIMIT];
  char_t clr_buf[WORD_LIMIT];
  int word_fill;
  int line_len;
  int coord_vals[NUM_SLOTS];
  int coord_slot;
  bit line_dropped;
  kind_t kind_now;
  logic [NUMBER_BITS-1:0] cmd_count;
  logic [CFG_DATA_BITS-1:0] width_reg, height_reg;

  // Command records still owed by the parser, oldest first.
  record_t cmd_expect_q[$];

  // Text of the line being sent.
  char_t text_q[$];

  typedef struct {
    string text;
    bit typed;
    bit gives;
    kind_t kind;
    paint_t colour;
    int xs, xe, ys, ye;
  } text_case_t;
  text_case_t text_cases[$];

  int mismatch_count = 0;
  int chars_sent = 0;
  int marks_sent = 0;
  int records_checked = 0;
  int lines_dropped = 0;
  int reg_writes = 0;
  int idle_cycles = 0;
  bit src_idle_on = 1'b1;
  bit sink_idle_on = 1'b1;
  int sink_hold = 0;

  task automatic report_error(input string msg);
    if (mismatch_count < 40)
      $display("ERROR at %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  function automatic void clear_line();
    int i;
    phase_now = PH_KEYWORD;
    for (i = 0; i < WORD_LIMIT; i++) begin
      kw_buf[i] = '0;
      clr_buf[i] = '0;
    end
    for (i = 0; i < NUM_SLOTS; i++)
      coord_vals[i] = 0;
    word_fill = 0;
    line_len = 0;
    coord_slot = 0;
    line_dropped = 1'b0;
    kind_now = KIND_BCKG;
  endfunction

  // True when the keyword or colour buffer holds exactly the given name.
  function automatic bit word_matches(input bit on_colour, input string name);
    int i;
    bit ok;
    ok = (word_fill == name.len());
    for (i = 0; ok && i < name.len(); i++)
      if ((on_colour ? clr_buf[i] : kw_buf[i]) != char_t'(name[i]))
        ok = 1'b0;
    return ok;
  endfunction

  function automatic void store_word_char(input bit on_colour, input char_t c);
    if (word_fill < WORD_LIMIT) begin
      if (on_colour)
        clr_buf[word_fill] = c;
      else
        kw_buf[word_fill] = c;
      word_fill++;
    end else begin
      line_dropped = 1'b1;
    end
  endfunction

  // Advances the shadow state by one character; returns 1 with the record
  // when the character is a newline that closes a well-formed line.
  function automatic bit predict_char(input char_t c, output record_t rec);
    int i, found, k, need, nv;
    rec = '0;
    if (c == CH_NEWLINE) begin
      found = -1;
      if (!line_dropped && phase_now == PH_COLOUR)
        for (i = 0; i < COLOUR_COUNT; i++)
          if (word_matches(1'b1, colour_words[i]))
            found = i;
      if (found < 0) begin
        clear_line();
        return 1'b0;
      end
      rec.kind = kind_now;
      rec.colour = paint_t'(found);
      case (kind_now)
        KIND_BCKG: begin
          rec.x_start = '0;
          rec.x_end = width_reg;
          rec.y_start = '0;
          rec.y_end = height_reg;
        end
        KIND_LINE_H: begin
          rec.x_start = COORD_OUT_BITS'(coord_vals[0]);
          rec.x_end = COORD_OUT_BITS'(coord_vals[1]);
          rec.y_start = COORD_OUT_BITS'(coord_vals[2]);
          rec.y_end = COORD_OUT_BITS'(coord_vals[2]);
        end
        KIND_LINE_V: begin
          rec.x_start = COORD_OUT_BITS'(coord_vals[0]);
          rec.x_end = COORD_OUT_BITS'(coord_vals[0]);
          rec.y_start = COORD_OUT_BITS'(coord_vals[1]);
          rec.y_end = COORD_OUT_BITS'(coord_vals[2]);
        end
        default: begin
          rec.x_start = COORD_OUT_BITS'(coord_vals[0]);
          rec.x_end = COORD_OUT_BITS'(coord_vals[1]);
          rec.y_start = COORD_OUT_BITS'(coord_vals[2]);
          rec.y_end = COORD_OUT_BITS'(coord_vals[3]);
        end
      endcase
      rec.number = cmd_count;
      cmd_count = cmd_count + NUMBER_BITS'(1);
      clear_line();
      return 1'b1;
    end
    if (c == CH_SPACE || line_dropped)
      return 1'b0;

    line_len++;
    if (line_len > LINE_LIMIT) begin
      line_dropped = 1'b1;
      return 1'b0;
    end

    case (phase_now)
      PH_KEYWORD: begin
        if (c == CH_COLON) begin
          k = -1;
          for (i = 0; i < KIND_COUNT; i++)
            if (word_matches(1'b0, kw_words[i]))
              k = i;
          if (k < 0) begin
            line_dropped = 1'b1;
          end else begin
            kind_now = kind_t'(k);
            word_fill = 0;
            phase_now = (kind_now == KIND_BCKG) ? PH_COLOUR : PH_NUMBERS;
          end
        end else begin
          store_word_char(1'b0, c);
        end
      end
      PH_NUMBERS: begin
        need = kw_arg_count[kind_now];
        if (c >= CH_ZERO && c <= CH_NINE) begin
          nv = coord_vals[coord_slot] * 10 + (int'(c) - int'(CH_ZERO));
          coord_vals[coord_slot] = (nv > COORD_LIMIT) ? COORD_LIMIT : nv;
        end else if (c == CH_COMMA) begin
          if (coord_slot + 1 >= need)
            line_dropped = 1'b1;
          else
            coord_slot++;
        end else if (c == CH_SEMI) begin
          if (coord_slot + 1 != need) begin
            line_dropped = 1'b1;
          end else begin
            word_fill = 0;
            phase_now = PH_COLOUR;
          end
        end else begin
          line_dropped = 1'b1;
        end
      end
      default: store_word_char(1'b1, c);
    endcase
    return 1'b0;
  endfunction

  // Sender gaps: mostly none, sometimes short, rarely long.
  function automatic int pick_gap();
    int r;
    if (!src_idle_on)
      return 0;
    r = $urandom_range(0, 99);
    if (r < 70)
      return 0;
    if (r < 95)
      return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Offers one character and waits for its transfer; when predicted is set
  // the record it closes is queued for checking.
  task automatic send_char(input char_t c, input bit predicted);
    int gap;
    record_t rec;
    bit got;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    char_code <= c;
    do @(posedge clk); while (!in_ready);
    chars_sent++;
    if (c != CH_SPACE)
      marks_sent++;
    got = predict_char(c, rec);
    if (got && predicted)
      cmd_expect_q.push_back(rec);
    if (c == CH_NEWLINE && !got)
      lines_dropped++;
  endtask

  task automatic send_line();
    int i;
    for (i = 0; i < text_q.size(); i++)
      send_char(text_q[i], 1'b1);
  endtask

  // Holds the sender until every queued record has been seen.
  task automatic drain_results();
    if (cmd_expect_q.size() != 0) begin
      in_valid <= 1'b0;
      while (cmd_expect_q.size() != 0) @(posedge clk);
    end
  endtask

  // Brings the parser to rest before a register write or the end of the run.
  task automatic settle();
    in_valid <= 1'b0;
    while (cmd_expect_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_FULL_WIDTH)
      width_reg = val;
    else if (idx == REG_FULL_HEIGHT)
      height_reg = val;
    reg_writes++;
    @(posedge clk);
  endtask

  task automatic add_case(input string text, input bit typed, input bit gives,
                          input kind_t kind, input paint_t colour,
                          input int xs, input int xe, input int ys, input int ye);
    text_case_t tc;
    tc.text = text;
    tc.typed = typed;
    tc.gives = gives;
    tc.kind = kind;
    tc.colour = colour;
    tc.xs = xs;
    tc.xe = xe;
    tc.ys = ys;
    tc.ye = ye;
    text_cases.push_back(tc);
  endtask

  // Random line building: stray spaces land between characters now and then.
  task automatic add_char(input char_t c);
    if ($urandom_range(0, 99) < 8)
      text_q.push_back(CH_SPACE);
    text_q.push_back(c);
  endtask

  task automatic add_word(input string s);
    int i;
    for (i = 0; i < s.len(); i++)
      add_char(char_t'(s[i]));
  endtask

  // Empty, short, saturating, or padded with many leading zeros.
  task automatic add_number();
    int n, r, i;
    r = $urandom_range(0, 99);
    if (r < 5)
      n = 0;
    else if (r < 80)
      n = $urandom_range(1, 4);
    else if (r < 95)
      n = $urandom_range(5, 6);
    else
      n = $urandom_range(20, 40);
    for (i = 0; i < n; i++)
      if (r >= 95 && i < n - 4)
        add_char(CH_ZERO);
      else
        add_char(char_t'(CH_ZERO + $urandom_range(0, 9)));
  endtask

  task automatic build_good_line();
    int k, i;
    text_q.delete();
    k = $urandom_range(0, KIND_COUNT - 1);
    add_word(kw_words[k]);
    add_char(CH_COLON);
    if (k != KIND_BCKG) begin
      for (i = 0; i < kw_arg_count[k]; i++) begin
        if (i > 0)
          add_char(CH_COMMA);
        add_number();
      end
      add_char(CH_SEMI);
    end
    add_word(colour_words[$urandom_range(0, COLOUR_COUNT - 1)]);
    add_char(CH_NEWLINE);
  endtask

  // Damages the current line, or replaces it with raw bytes.
  task automatic break_line();
    string junk;
    int pos, i, n;
    junk = ",;:0x";
    pos = $urandom_range(0, text_q.size() - 2);
    case ($urandom_range(0, 3))
      0: begin
        text_q.delete();
        n = $urandom_range(1, 24);
        for (i = 0; i < n; i++)
          text_q.push_back(char_t'($urandom_range(0, 255)));
        text_q.push_back(CH_NEWLINE);
      end
      1: text_q[pos] = char_t'($urandom_range(0, 255));
      2: text_q.delete(pos);
      default: text_q.insert(pos, char_t'(junk[$urandom_range(0, 4)]));
    endcase
  endtask

  // Ready pattern of the result side.
  always @(posedge clk) begin : sink_pattern
    int r;
    if (!sink_idle_on) begin
      out_ready <= 1'b1;
    end else if (sink_hold > 0) begin
      sink_hold <= sink_hold - 1;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 60) begin
        out_ready <= 1'b1;
        sink_hold <= $urandom_range(0, 5);
      end else if (r < 95) begin
        out_ready <= 1'b0;
        sink_hold <= $urandom_range(0, 3);
      end else begin
        out_ready <= 1'b0;
        sink_hold <= $urandom_range(10, 40);
      end
    end
  end

  // Each record transfer is compared with the oldest expected record.
  always @(posedge clk) begin : result_check
    record_t want;
    if (!rst && out_valid && out_ready) begin
      if (cmd_expect_q.size() == 0) begin
        report_error($sformatf("record number %0d arrived with nothing expected",
                               command_number));
      end else begin
        want = cmd_expect_q.pop_front();
        records_checked++;
        if (command_kind !== want.kind)
          report_error($sformatf("command_kind got %0d expected %0d",
                                 command_kind, want.kind));
        if (colour_code !== want.colour)
          report_error($sformatf("colour_code got %0d expected %0d",
                                 colour_code, want.colour));
        if (x_start !== want.x_start)
          report_error($sformatf("x_start got %0d expected %0d", x_start, want.x_start));
        if (x_end !== want.x_end)
          report_error($sformatf("x_end got %0d expected %0d", x_end, want.x_end));
        if (y_start !== want.y_start)
          report_error($sformatf("y_start got %0d expected %0d", y_start, want.y_start));
        if (y_end !== want.y_end)
          report_error($sformatf("y_end got %0d expected %0d", y_end, want.y_end));
        if (command_number !== want.number)
          report_error($sformatf("command_number got %0d expected %0d",
                                 command_number, want.number));
      end
    end
  end

  // Ends the run when no character or register transfer happens for too long.
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && in_ready) || (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Timeout: no transfer for %0d cycles", STALL_LIMIT);
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  initial begin : stimulus
    string long_line, edge_line;
    record_t rec;
    logic [NUMBER_BITS-1:0] base;
    char_t ch;
    int n, j, ph, phase_marks;

    width_reg = FULL_WIDTH_RST;
    height_reg = FULL_HEIGHT_RST;
    cmd_count = '0;
    clear_line();

    // Lines just over and exactly at the length limit.
    long_line = "RECT:1,2,3,";
    repeat (120) long_line = {long_line, "0"};
    long_line = {long_line, "4;RED\n"};
    edge_line = "RECT:1,2,3,";
    repeat (112) edge_line = {edge_line, "0"};
    edge_line = {edge_line, "4;RED\n"};

    // Directed text: typed rows carry their expected record or a drop.
    add_case("BCKG:RED\n", 1, 1, KIND_BCKG, CLR_RED, 0, 640, 0, 480);
    add_case("LINE_H:0,4095,7;GREEN\n", 1, 1, KIND_LINE_H, CLR_GREEN, 0, 4095, 7, 7);
    add_case("LINE_V:12,0,4095;BLUE\n", 1, 1, KIND_LINE_V, CLR_BLUE, 12, 12, 0, 4095);
    add_case("RECT:1,2,3,4;YELLOW\n", 1, 1, KIND_RECT, CLR_YELLOW, 1, 2, 3, 4);
    add_case("RECT:99999,4096,,5;WHITE\n", 1, 1, KIND_RECT, CLR_WHITE, 4095, 4095, 0, 5);
    add_case(" B C K G : BLACK \n", 1, 1, KIND_BCKG, CLR_BLACK, 0, 640, 0, 480);
    add_case("\n", 1, 0, KIND_BCKG, CLR_RED, 0, 0, 0, 0);
    add_case("BCKG RED\n", 1, 0, KIND_BCKG, CLR_RED, 0, 0, 0, 0);
    add_case(":RED\n", 1, 0, KIND_BCKG, CLR_RED, 0, 0, 0, 0);
    add_case("CIRC:1,2;RED\n", 1, 0, KIND_BCKG, CLR_RED, 0, 0, 0, 0);
    add_case("LINE_H:1,2;RED\n", 1, 0, KIND_BCKG, CLR_RED, 0, 0, 0, 0);
    add_case("LINE_H:1,2,3,4;RED\n", 1, 0, KIND_BCKG, CLR_RED, 0, 0, 0, 0);
    add_case("RECT:1,2,3,4RED\n", 1, 0, KIND_BCKG, CLR_RED, 0, 0, 0, 0);
    add_case("LINE_V:1,x,3;RED\n", 1, 0, KIND_BCKG, CLR_RED, 0, 0, 0, 0);
    add_case("LINE_V:1,2,3;GREEN\n", 0, 0, KIND_BCKG, CLR_RED, 0, 0, 0, 0);
    add_case("BCKG:PINK\n", 1, 0, KIND_BCKG, CLR_RED, 0, 0, 0, 0);
    add_case("RECT:1,2,3,4;\n", 1, 0, KIND_BCKG, CLR_RED, 0, 0, 0, 0);
    add_case("BCKG:1;RED\n", 1, 0, KIND_BCKG, CLR_RED, 0, 0, 0, 0);
    add_case("LINE_HORIZ:1,2,3;RED\n", 1, 0, KIND_BCKG, CLR_RED, 0, 0, 0, 0);
    add_case("BCKG:REDREDRED\n", 1, 0, KIND_BCKG, CLR_RED, 0, 0, 0, 0);
    // A carriage return before the newline is an ordinary character.
    add_case("BCKG:RED\015\n", 1, 0, KIND_BCKG, CLR_RED, 0, 0, 0, 0);
    add_case("BCKG:@RED\n", 1, 0, KIND_BCKG, CLR_RED, 0, 0, 0, 0);
    add_case(long_line, 1, 0, KIND_BCKG, CLR_RED, 0, 0, 0, 0);
    add_case(edge_line, 0, 0, KIND_BCKG, CLR_RED, 0, 0, 0, 0);
    add_case("RECT: 1 0 , 2 ,3,4;RED\n", 0, 0, KIND_BCKG, CLR_RED, 0, 0, 0, 0);
    add_case("LINE_H:,,;BLACK\n", 0, 0, KIND_BCKG, CLR_RED, 0, 0, 0, 0);

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed part.
    for (n = 0; n < text_cases.size(); n++) begin
      base = cmd_count;
      for (j = 0; j < text_cases[n].text.len(); j++) begin
        ch = char_t'(text_cases[n].text[j]);
        if (ch == NUL_MARK)
          ch = '0;
        send_char(ch, !text_cases[n].typed);
      end
      if (text_cases[n].typed && text_cases[n].gives) begin
        rec.kind = text_cases[n].kind;
        rec.colour = text_cases[n].colour;
        rec.x_start = COORD_OUT_BITS'(text_cases[n].xs);
        rec.x_end = COORD_OUT_BITS'(text_cases[n].xe);
        rec.y_start = COORD_OUT_BITS'(text_cases[n].ys);
        rec.y_end = COORD_OUT_BITS'(text_cases[n].ye);
        rec.number = base;
        cmd_expect_q.push_back(rec);
      end
    end

    // Random part in phases, each with its own screen size.
    for (ph = 0; ph < 4; ph++) begin
      settle();
      case (ph)
        0: begin
          write_reg(REG_FULL_WIDTH, 12'd4095);
          write_reg(REG_FULL_HEIGHT, 12'd1);
        end
        1: begin
          write_reg(REG_FULL_WIDTH, 12'd1);
          write_reg(REG_FULL_HEIGHT, 12'd4095);
          // Indexes past the two registers must leave both untouched.
          write_reg(REG_SPARE_LO, 12'($urandom_range(0, 4095)));
          write_reg(REG_SPARE_HI, 12'($urandom_range(0, 4095)));
        end
        default: begin
          write_reg(REG_FULL_WIDTH, 12'($urandom_range(1, 4095)));
          write_reg(REG_FULL_HEIGHT, 12'($urandom_range(1, 4095)));
        end
      endcase
      // The second phase runs with no idling on either side.
      src_idle_on = (ph != 1);
      sink_idle_on = (ph != 1);
      phase_marks = marks_sent;
      while (marks_sent - phase_marks < PHASE_CHARS) begin
        build_good_line();
        if ($urandom_range(0, 99) < 25)
          break_line();
        if ($urandom_range(0, 99) < 3)
          drain_results();
        send_line();
      end
    end

    settle();
    repeat (2) @(posedge clk);
    $display("Sent %0d characters (%0d non-space) over %0d register writes;",
             chars_sent, marks_sent, reg_writes);
    $display("checked %0d command records and saw %0d lines dropped.",
             records_checked, lines_dropped);
    if (mismatch_count == 0 && cmd_expect_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
